// ===== sv/brte_pkg.sv =====
`default_nettype none
package brte_pkg;

   // result status codes
   localparam logic [1:0] STATUS_VALID     = 2'd0;
   localparam logic [1:0] STATUS_BAD_DATE  = 2'd1;
   localparam logic [1:0] STATUS_LOW_EPOCH = 2'd2;

   // register index as seen on paddr[2]
   localparam logic       CSR_MIN_EPOCH_INDEX = 1'b0;
   localparam logic [31:0] MIN_EPOCH_RESET    = 32'd1577836800;

   localparam logic [11:0] YEAR_BASE   = 12'd2000;
   localparam logic [11:0] ERA4_START  = 12'd1600;
   localparam logic [11:0] ERA5_START  = 12'd2000;
   // |era*146097 - 719468| for the two eras the year range can reach
   localparam logic [17:0] ERA5_OFFSET = 18'd11017;
   localparam logic [17:0] ERA4_OFFSET = 18'd135080;
   localparam logic [17:0] DAYS_PER_YEAR   = 18'd365;
   localparam logic [17:0] SECS_PER_HOUR   = 18'd3600;
   localparam logic [17:0] SECS_PER_MINUTE = 18'd60;
   localparam logic [31:0] SECS_PER_DAY    = 32'd86400;

   typedef struct packed {
      logic [7:0] seconds_byte;
      logic [7:0] minutes_byte;
      logic [7:0] hours_byte;
      logic [7:0] date_byte;
      logic [7:0] month_byte;
      logic [7:0] year_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] epoch_seconds;
      logic [1:0]  status;
   } rsp_type;

   // after nibble decode
   typedef struct packed {
      logic [6:0]  sec;
      logic [6:0]  min;
      logic [5:0]  hour;
      logic [5:0]  day;
      logic [3:0]  mp;
      logic [11:0] year;
      logic        bad;
   } dec_type;

   // after day count
   typedef struct packed {
      logic [16:0] days;
      logic [17:0] hms;
      logic        bad;
   } days_type;

   function automatic logic [7:0] bcd_decode(input logic [7:0] b);
      return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
   endfunction

   // (153 * mp + 2) / 5, march-based month start
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] r;
      case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== sv/brte_csr.sv =====
`default_nettype none
module brte_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output logic [31:0]      min_epoch
);

   logic [31:0] min_epoch_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr[2] == brte_pkg::CSR_MIN_EPOCH_INDEX);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_epoch_ff <= brte_pkg::MIN_EPOCH_RESET;
      end else if (wr_en) begin
         min_epoch_ff <= pwdata;
      end
   end

   // byte lanes within the word are not decoded
   assign prdata    = (paddr[2] == brte_pkg::CSR_MIN_EPOCH_INDEX) ? min_epoch_ff : 32'd0;
   assign min_epoch = min_epoch_ff;

endmodule
`default_nettype wire

// ===== sv/brte_decode.sv =====
`default_nettype none
module brte_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire brte_pkg::req_type in_data,
   output logic                   out_valid,
   output brte_pkg::dec_type      out_data
);

   logic              valid_ff;
   brte_pkg::dec_type data_ff;
   brte_pkg::dec_type data_in;
   logic [7:0]        sec8, min8, hour8, day8, mon8, year8;
   logic [4:0]        month;
   logic [4:0]        mp5;

   always_comb begin
      sec8  = brte_pkg::bcd_decode({1'b0, in_data.seconds_byte[6:0]});
      min8  = brte_pkg::bcd_decode({1'b0, in_data.minutes_byte[6:0]});
      hour8 = brte_pkg::bcd_decode({2'b00, in_data.hours_byte[5:0]});
      day8  = brte_pkg::bcd_decode({2'b00, in_data.date_byte[5:0]});
      mon8  = brte_pkg::bcd_decode({3'b000, in_data.month_byte[4:0]});
      year8 = brte_pkg::bcd_decode(in_data.year_byte);
      month = mon8[4:0];
      // march-based month index, jan and feb belong to the year before
      mp5   = (month > 5'd2) ? (month - 5'd3) : (month + 5'd9);

      data_in.sec  = sec8[6:0];
      data_in.min  = min8[6:0];
      data_in.hour = hour8[5:0];
      data_in.day  = day8[5:0];
      data_in.mp   = mp5[3:0];
      data_in.year = brte_pkg::YEAR_BASE + {4'b0000, year8} - {11'd0, (month <= 5'd2)};
      data_in.bad  = (month == 5'd0) || (month > 5'd12) ||
                     (day8[5:0] == 6'd0) || (day8[5:0] > 6'd31);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ===== sv/brte_days.sv =====
`default_nettype none
module brte_days (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire brte_pkg::dec_type in_data,
   output logic                   out_valid,
   output brte_pkg::days_type     out_data
);

   logic               valid_ff;
   brte_pkg::days_type data_ff;
   brte_pkg::days_type data_in;
   logic               era5;
   logic [11:0]        yoe12;
   logic [8:0]         yoe;
   logic [1:0]         cent;
   logic [17:0]        doe;
   logic [17:0]        days18;

   always_comb begin
      // year range only reaches eras 4 and 5
      era5  = (in_data.year >= brte_pkg::ERA5_START);
      yoe12 = in_data.year - (era5 ? brte_pkg::ERA5_START : brte_pkg::ERA4_START);
      yoe   = yoe12[8:0];
      if (yoe >= 9'd300)      cent = 2'd3;
      else if (yoe >= 9'd200) cent = 2'd2;
      else if (yoe >= 9'd100) cent = 2'd1;
      else                    cent = 2'd0;

      doe = ({9'd0, yoe} * brte_pkg::DAYS_PER_YEAR) + {11'd0, yoe[8:2]} - {16'd0, cent}
          + {9'd0, brte_pkg::month_start(in_data.mp)} + {12'd0, in_data.day} - 18'd1;
      days18 = era5 ? (doe + brte_pkg::ERA5_OFFSET) : (doe - brte_pkg::ERA4_OFFSET);

      data_in.days = days18[16:0];
      data_in.hms  = ({12'd0, in_data.hour} * brte_pkg::SECS_PER_HOUR)
                   + ({11'd0, in_data.min} * brte_pkg::SECS_PER_MINUTE)
                   + {11'd0, in_data.sec};
      data_in.bad  = in_data.bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ===== sv/brte_epoch.sv =====
`default_nettype none
module brte_epoch (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en_mul,
   input  wire logic               en_out,
   input  wire logic               in_valid,
   input  wire brte_pkg::days_type in_data,
   input  wire logic [31:0]        min_epoch,
   output logic                    mul_valid,
   output logic                    out_valid,
   output brte_pkg::rsp_type       out_data
);

   logic              mul_valid_ff;
   logic [31:0]       prod_ff;
   logic [17:0]       hms_ff;
   logic              bad_ff;
   logic              out_valid_ff;
   brte_pkg::rsp_type out_ff;
   brte_pkg::rsp_type out_in;
   logic [31:0]       epoch;

   // multiply stage, only the low 32 bits of the product matter
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (en_mul) begin
         mul_valid_ff <= in_valid;
      end
      if (en_mul) begin
         prod_ff <= {15'd0, in_data.days} * brte_pkg::SECS_PER_DAY;
         hms_ff  <= in_data.hms;
         bad_ff  <= in_data.bad;
      end
   end

   always_comb begin
      epoch = prod_ff + {14'd0, hms_ff};
      if (bad_ff) begin
         out_in.epoch_seconds = 32'd0;
         out_in.status        = brte_pkg::STATUS_BAD_DATE;
      end else begin
         out_in.epoch_seconds = epoch;
         out_in.status        = (epoch > min_epoch) ? brte_pkg::STATUS_VALID
                                                    : brte_pkg::STATUS_LOW_EPOCH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en_out) begin
         out_valid_ff <= mul_valid_ff;
      end
      if (en_out) begin
         out_ff <= out_in;
      end
   end

   assign mul_valid = mul_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule
`default_nettype wire

// ===== sv/bcd_rtc_time_to_unix_epoch.sv =====
`default_nettype none
// channel   direction  payload                   handshake
// req       in         brte_pkg::req_type        req_valid / req_stall
// rsp       out        brte_pkg::rsp_type        rsp_valid / rsp_stall
// csr       in/out     epoch floor at 0x0        psel penable pwrite / pready
//
// one item per cycle while rsp_stall is low; a result passes through the registered stages
// decode, day count, multiply by 86400, then add and compare, in that order
// the 17x17 day-to-seconds multiply has a stage of its own
// reset clears all stage valid bits and loads the epoch floor with its default
// each stage refills when it is empty or its successor moves, so bubbles close up
// under rsp_stall and req_stall rises only once every stage holds an item
module bcd_rtc_time_to_unix_epoch (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire brte_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output brte_pkg::rsp_type      rsp_payload,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   logic               dec_valid, days_valid, mul_valid;
   brte_pkg::dec_type  dec_data;
   brte_pkg::days_type days_data;
   logic [31:0]        min_epoch;
   logic               en_dec, en_days, en_mul, en_out;

   assign en_out    = !rsp_valid || !rsp_stall;
   assign en_mul    = !mul_valid || en_out;
   assign en_days   = !days_valid || en_mul;
   assign en_dec    = !dec_valid || en_days;
   assign req_stall = !en_dec;

   brte_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .min_epoch (min_epoch)
   );

   brte_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .en        (en_dec),
      .in_valid  (req_valid),
      .in_data   (req_payload),
      .out_valid (dec_valid),
      .out_data  (dec_data)
   );

   brte_days u_days (
      .clock     (clock),
      .reset     (reset),
      .en        (en_days),
      .in_valid  (dec_valid),
      .in_data   (dec_data),
      .out_valid (days_valid),
      .out_data  (days_data)
   );

   brte_epoch u_epoch (
      .clock     (clock),
      .reset     (reset),
      .en_mul    (en_mul),
      .en_out    (en_out),
      .in_valid  (days_valid),
      .in_data   (days_data),
      .min_epoch (min_epoch),
      .mul_valid (mul_valid),
      .out_valid (rsp_valid),
      .out_data  (rsp_payload)
   );

   // a transfer always lands in the decode stage
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> dec_valid)
      else $error("accepted item missing from decode stage");

   // backpressure only when the whole pipe is full and the output is held
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (dec_valid && days_valid && mul_valid && rsp_valid && rsp_stall))
      else $error("input stalled with room in the pipeline");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status == brte_pkg::STATUS_BAD_DATE))
         |-> (rsp_payload.epoch_seconds == 32'd0))
      else $error("bad date result carries a nonzero epoch");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status == brte_pkg::STATUS_LOW_EPOCH))
         |-> (rsp_payload.epoch_seconds <= min_epoch))
      else $error("low epoch status above the minimum");

endmodule
`default_nettype wire

// ===== test/tb_bcd_rtc_time_to_unix_epoch.sv =====
`timescale 1ns / 1ps
module tb_bcd_rtc_time_to_unix_epoch;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      int unsigned       item_id;
      brte_pkg::rsp_type result;
   } pending_epoch_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   brte_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   brte_pkg::rsp_type rsp_payload;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [2:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   pending_epoch_type expected_epochs[$];
   logic [31:0]       min_epoch_model = brte_pkg::MIN_EPOCH_RESET;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   logic              hold_off = 1'b0;
   int unsigned       items_sent = 0;
   int unsigned       results_checked = 0;
   int unsigned       settings_applied = 0;
   int unsigned       mismatches = 0;
   int unsigned       cycle_count = 0;

   bcd_rtc_time_to_unix_epoch dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #1 clock = ~clock;

   // receiver side: random stall plus the long hold-off
   always @(posedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
   end

   function automatic int unsigned bcd_weight(input logic [7:0] b);
      return b[7:4] * 10 + b[3:0];
   endfunction

   function automatic brte_pkg::rsp_type predict_epoch(input brte_pkg::req_type stamp,
                                                       input logic [31:0] min_epoch);
      longint unsigned sec, minute, hour, day, month, year;
      longint unsigned y, era, yoe, mp, doy, doe, total;
      brte_pkg::rsp_type r;
      sec    = bcd_weight(stamp.seconds_byte & 8'h7F);
      minute = bcd_weight(stamp.minutes_byte & 8'h7F);
      hour   = bcd_weight(stamp.hours_byte & 8'h3F);
      day    = bcd_weight(stamp.date_byte & 8'h3F);
      month  = bcd_weight(stamp.month_byte & 8'h1F);
      year   = 2000 + bcd_weight(stamp.year_byte);
      if (month < 1 || month > 12 || day < 1 || day > 31) begin
         r.epoch_seconds = '0;
         r.status = brte_pkg::STATUS_BAD_DATE;
         return r;
      end
      // march-based year so the leap day falls at the end
      y   = (month <= 2) ? year - 1 : year;
      era = y / 400;
      yoe = y - era * 400;
      mp  = (month > 2) ? month - 3 : month + 9;
      doy = (153 * mp + 2) / 5 + day - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      total = era * 146097 + doe - 719468;
      total = total * 86400 + hour * 3600 + minute * 60 + sec;
      r.epoch_seconds = total[31:0];
      r.status = (r.epoch_seconds > min_epoch) ? brte_pkg::STATUS_VALID
                                               : brte_pkg::STATUS_LOW_EPOCH;
      return r;
   endfunction

   function automatic brte_pkg::req_type stamp(input logic [7:0] year,
                                               input logic [7:0] month,
                                               input logic [7:0] date,
                                               input logic [7:0] hour,
                                               input logic [7:0] minute,
                                               input logic [7:0] second);
      return {second, minute, hour, date, month, year};
   endfunction

   // bcd digits with random junk in the bits the block ignores
   function automatic logic [7:0] to_bcd(input int unsigned v, input logic [7:0] junk_mask);
      return {4'(v / 10), 4'(v % 10)} | (8'($urandom) & junk_mask);
   endfunction

   function automatic brte_pkg::req_type random_stamp();
      int unsigned kind;
      brte_pkg::req_type s;
      kind = $urandom_range(99);
      s = stamp(to_bcd($urandom_range(99), 8'h00), to_bcd($urandom_range(12, 1), 8'hE0),
                to_bcd($urandom_range(31, 1), 8'hC0), to_bcd($urandom_range(23), 8'hC0),
                to_bcd($urandom_range(59), 8'h80), to_bcd($urandom_range(59), 8'h80));
      if (kind >= 85) begin
         s = brte_pkg::req_type'({$urandom(), 16'($urandom())});
      end else if (kind >= 65) begin
         case ($urandom_range(5))
            0: s.seconds_byte = 8'($urandom());
            1: s.minutes_byte = 8'($urandom());
            2: s.hours_byte   = 8'($urandom());
            3: s.date_byte    = 8'($urandom());
            4: s.month_byte   = 8'($urandom());
            default: s.year_byte = 8'($urandom());
         endcase
      end
      return s;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      mismatches++;
   endtask

   task automatic send_timestamp(input brte_pkg::req_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= s;
      do @(posedge clock); while (req_stall);
      expected_epochs.push_back('{items_sent, predict_epoch(s, min_epoch_model)});
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_epochs.size() != 0) @(posedge clock);
   endtask

   task automatic write_min_epoch(input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {brte_pkg::CSR_MIN_EPOCH_INDEX, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      min_epoch_model = value;
      settings_applied++;
      @(posedge clock);
   endtask

   task automatic read_min_epoch();
      logic [31:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {brte_pkg::CSR_MIN_EPOCH_INDEX, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== min_epoch_model)
         report_mismatch("epoch floor readback", got, min_epoch_model);
      @(posedge clock);
   endtask

   always @(posedge clock) begin : check_results
      pending_epoch_type pending;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_epochs.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_payload.epoch_seconds, 0);
         end else begin
            pending = expected_epochs.pop_front();
            if (rsp_payload.epoch_seconds !== pending.result.epoch_seconds)
               report_mismatch($sformatf("item %0d epoch_seconds", pending.item_id),
                               rsp_payload.epoch_seconds, pending.result.epoch_seconds);
            if (rsp_payload.status !== pending.result.status)
               report_mismatch($sformatf("item %0d status", pending.item_id),
                               rsp_payload.status, pending.result.status);
            results_checked++;
         end
      end
   end

   task automatic test_register_access();
      read_min_epoch();
      write_min_epoch(32'd0);
      read_min_epoch();
      write_min_epoch(32'hFFFF_FFFF);
      read_min_epoch();
      write_min_epoch(brte_pkg::MIN_EPOCH_RESET);
      read_min_epoch();
   endtask

   task automatic test_field_extremes();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_timestamp(stamp(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));  // month zero
      send_timestamp(stamp(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));  // month 25
      send_timestamp(stamp(8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00));
      // exactly the default threshold, then one second past it
      send_timestamp(stamp(8'h20, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00));
      send_timestamp(stamp(8'h20, 8'h01, 8'h01, 8'h00, 8'h00, 8'h01));
      send_timestamp(stamp(8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59));
      send_timestamp(stamp(8'hFF, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59));  // wraps 32 bits
      send_timestamp(stamp(8'h9F, 8'h06, 8'h15, 8'h12, 8'h30, 8'h30));
      send_timestamp(stamp(8'h24, 8'h13, 8'h01, 8'h00, 8'h00, 8'h00));
      send_timestamp(stamp(8'h24, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00));
      send_timestamp(stamp(8'h24, 8'hE1, 8'hC1, 8'hC0, 8'h80, 8'h80));  // control bits set
      send_timestamp(stamp(8'h24, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00));
      send_timestamp(stamp(8'h24, 8'h05, 8'h32, 8'h00, 8'h00, 8'h00));
      send_timestamp(stamp(8'h24, 8'h05, 8'h3F, 8'h00, 8'h00, 8'h00));
      send_timestamp(stamp(8'h24, 8'h05, 8'h1F, 8'h00, 8'h00, 8'h00));  // date 25 from non-bcd
      send_timestamp(stamp(8'h23, 8'h02, 8'h31, 8'h00, 8'h00, 8'h00));  // feb 31 runs on
      send_timestamp(stamp(8'h01, 8'h02, 8'h29, 8'h00, 8'h00, 8'h00));
      send_timestamp(stamp(8'h00, 8'h02, 8'h29, 8'h23, 8'h59, 8'h59));
      send_timestamp(stamp(8'hA0, 8'h02, 8'h29, 8'h00, 8'h00, 8'h00));  // 2100 is not leap
      send_timestamp(stamp(8'hA0, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00));
      send_timestamp(stamp(8'h24, 8'h07, 8'h04, 8'h3F, 8'h7F, 8'hFF));  // oversized h/m/s
      send_timestamp(stamp(8'h24, 8'h07, 8'h04, 8'hFF, 8'hFF, 8'h7F));
      wait_for_results();
   endtask

   task automatic test_min_epoch_boundary();
      brte_pkg::req_type s;
      brte_pkg::rsp_type want;
      logic [31:0] e;
      s = stamp(to_bcd($urandom_range(99), 8'h00), to_bcd($urandom_range(12, 1), 8'h00),
                to_bcd($urandom_range(28, 1), 8'h00), to_bcd($urandom_range(23), 8'h00),
                to_bcd($urandom_range(59), 8'h00), to_bcd($urandom_range(59), 8'h00));
      want = predict_epoch(s, 32'd0);
      e = want.epoch_seconds;
      write_min_epoch(e);
      send_timestamp(s);
      wait_for_results();
      write_min_epoch(e - 32'd1);
      send_timestamp(s);
      wait_for_results();
      write_min_epoch(32'd0);
      send_timestamp(s);
      wait_for_results();
      write_min_epoch(32'hFFFF_FFFF);
      send_timestamp(s);
      wait_for_results();
   endtask

   // output held off long enough that the pipe fills and backs up the input
   task automatic test_output_hold_off();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_min_epoch(brte_pkg::MIN_EPOCH_RESET);
      fork
         begin
            hold_off <= 1'b1;
            repeat (80) @(posedge clock);
            hold_off <= 1'b0;
         end
      join_none
      repeat (40) send_timestamp(random_stamp());
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
                                      input logic [31:0] min_epoch);
      write_min_epoch(min_epoch);
      read_min_epoch();
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) send_timestamp(random_stamp());
      wait_for_results();
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_epochs.size());
      $display("bcd_rtc_time_to_unix_epoch verification failed");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_register_access();
      test_field_extremes();
      test_min_epoch_boundary();
      test_output_hold_off();
      test_random_traffic(280, 28, 55, 32'd0);
      test_random_traffic(280, 28, 55, $urandom_range(32'hFFFF_FFFF, 32'd946684800));
      test_random_traffic(280, 55, 28, 32'hFFFF_FFFF);
      test_random_traffic(280, 55, 28, $urandom_range(32'hFFFF_FFFF, 32'd946684800));
      test_random_traffic(280, 0, 0, brte_pkg::MIN_EPOCH_RESET);
      test_random_traffic(280, 0, 0, $urandom());
      recv_idle_pct = 0;
      repeat (10) @(posedge clock);
      while (expected_epochs.size() != 0) begin
         pending_epoch_type left;
         left = expected_epochs.pop_front();
         report_mismatch($sformatf("item %0d never returned", left.item_id), 0, 1);
      end
      $display("%0d timestamps sent, %0d results checked, %0d threshold writes",
               items_sent, results_checked, settings_applied);
      $display("bad dates, non-bcd digits, 32-bit wrap, threshold edges, output hold-off, "
               , "three idle mixes");
      if (mismatches == 0) begin
         $display("bcd_rtc_time_to_unix_epoch verification clean");
      end else begin
         $display("bcd_rtc_time_to_unix_epoch verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/brte_pkg.sv
sv/brte_csr.sv
sv/brte_decode.sv
sv/brte_days.sv
sv/brte_epoch.sv
sv/bcd_rtc_time_to_unix_epoch.sv
test/tb_bcd_rtc_time_to_unix_epoch.sv
